// ===== rtl/ipv4dq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ipv4dq_pkg;

    localparam logic [31:0] ALL_ONES_ADDR = 32'hFFFF_FFFF;
    localparam logic [11:0] OCTET_MAX     = 12'd255;
    localparam logic [7:0]  CHAR_NUL      = 8'h00;
    localparam logic [7:0]  CHAR_DOT      = 8'h2E;
    localparam logic [7:0]  CHAR_ZERO     = 8'h30;
    localparam logic [7:0]  CHAR_NINE     = 8'h39;
    localparam logic [1:0]  LAST_DOT_CNT  = 2'd3;

    typedef struct packed {
        logic [31:0] address;
        logic        parse_error;
    } t_result;

endpackage
`default_nettype wire

// ===== rtl/ipv4dq_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ipv4dq_core
    import ipv4dq_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic [7:0] i_char,
    output t_result         o_result
);

    logic [7:0]  r_octet_value;
    logic [1:0]  r_octet_count;
    logic        r_digit_present;
    logic        r_error_latched;
    logic [7:0]  r_done_octets [3];

    logic [7:0]  n_octet_value;
    logic [1:0]  n_octet_count;
    logic        n_digit_present;
    logic        n_error_latched;
    logic        store_en;

    logic        is_nul;
    logic        is_dot;
    logic        is_digit;
    logic [3:0]  digit;
    logic [11:0] acc;
    logic        bad;

    assign is_nul   = (i_char == CHAR_NUL);
    assign is_dot   = (i_char == CHAR_DOT);
    assign is_digit = (i_char >= CHAR_ZERO) && (i_char <= CHAR_NINE);
    assign digit    = 4'(i_char - CHAR_ZERO);
    // times ten as two shifts and an add
    assign acc      = {1'b0, r_octet_value, 3'b000} + {3'b000, r_octet_value, 1'b0}
                    + {8'h00, digit};

    assign bad = r_error_latched || !r_digit_present || (r_octet_count != LAST_DOT_CNT);

    always_comb begin
        if (bad) begin
            o_result.address     = ALL_ONES_ADDR;
            o_result.parse_error = 1'b1;
        end else begin
            o_result.address     = {r_octet_value, r_done_octets[2],
                                    r_done_octets[1], r_done_octets[0]};
            o_result.parse_error = 1'b0;
        end
    end

    always_comb begin
        n_octet_value   = r_octet_value;
        n_octet_count   = r_octet_count;
        n_digit_present = r_digit_present;
        n_error_latched = r_error_latched;
        store_en        = 1'b0;
        if (is_nul) begin
            n_octet_value   = '0;
            n_octet_count   = '0;
            n_digit_present = 1'b0;
            n_error_latched = 1'b0;
        end else if (!r_error_latched) begin
            if (is_digit) begin
                if (acc > OCTET_MAX) begin
                    n_error_latched = 1'b1;
                end else begin
                    n_octet_value   = acc[7:0];
                    n_digit_present = 1'b1;
                end
            end else if (is_dot) begin
                if (!r_digit_present || r_octet_count == LAST_DOT_CNT) begin
                    n_error_latched = 1'b1;
                end else begin
                    store_en        = 1'b1;
                    n_octet_count   = r_octet_count + 2'd1;
                    n_octet_value   = '0;
                    n_digit_present = 1'b0;
                end
            end else begin
                n_error_latched = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_octet_value   <= '0;
            r_octet_count   <= '0;
            r_digit_present <= 1'b0;
            r_error_latched <= 1'b0;
        end else if (i_step) begin
            r_octet_value   <= n_octet_value;
            r_octet_count   <= n_octet_count;
            r_digit_present <= n_digit_present;
            r_error_latched <= n_error_latched;
        end
    end

    // closed octets are only read once the count shows them written
    always_ff @(posedge i_clk) begin
        if (i_step && store_en) begin
            r_done_octets[r_octet_count] <= r_octet_value;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/ipv4_dotted_quad_parser_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Dotted-quad IPv4 text parser. Takes one character beat per cycle; a NUL
// byte ends the string and yields one result beat, registered first in the
// input register, then in the result register. The address carries the first
// octet in bits 7:0; any malformed string gives all ones with parse_error set.
// Input stalls only while a NUL beat waits behind a result that is stalled.
module ipv4_dotted_quad_parser_top
    import ipv4dq_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_char_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [31:0]      o_address,
    output logic             o_parse_error
);

    logic        r_in_valid;
    logic [7:0]  r_char;
    logic        r_out_valid;
    t_result     r_result;

    logic        out_free;
    logic        step;
    logic        step_nul;
    logic        in_take;
    t_result     core_result;

    assign out_free   = !r_out_valid || !i_out_stall;
    // a NUL beat needs room in the result register; other bytes always advance
    assign step       = r_in_valid && ((r_char != CHAR_NUL) || out_free);
    assign step_nul   = step && (r_char == CHAR_NUL);
    assign o_in_stall = r_in_valid && !step;
    assign in_take    = i_in_valid && !o_in_stall;

    ipv4dq_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_char   (r_char),
        .o_result (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (step) begin
                r_in_valid <= 1'b0;
            end
            if (step_nul) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_char <= i_char_byte;
        end
        if (step_nul) begin
            r_result <= core_result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_address     = r_result.address;
    assign o_parse_error = r_result.parse_error;

endmodule
`default_nettype wire

// ===== rtl/ipv4dq_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ipv4dq_checker
    import ipv4dq_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        o_in_stall,
    input  wire logic        o_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [31:0] o_address,
    input  wire logic        o_parse_error
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_address) && $stable(o_parse_error))
        else $error("result beat changed while stalled");

    a_err_all_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_parse_error |-> o_address == ALL_ONES_ADDR)
        else $error("error result without all-ones address");

    a_reset_idle: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result beat right after reset");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a blocked result");

endmodule

bind ipv4_dotted_quad_parser_top ipv4dq_checker u_ipv4dq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_address     (o_address),
    .o_parse_error (o_parse_error)
);
`default_nettype wire
